FILE: rtl/sit_pkg.sv
// Shared types and constants for the sorted interval table.
// Used by every module in rtl/; depends on nothing.
package sit_pkg;

  localparam int TIME_W      = 32;
  localparam int ENTRIES_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;

  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_READ_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NONE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    time_t t_start;
    time_t t_end;
  } entry_t;

  typedef struct packed {
    logic   hit;
    entry_t ent;
  } cmp_res_t;

  typedef struct packed {
    entry_t  ent;
    status_t status;
    logic    last;
  } result_t;

endpackage

FILE: rtl/sit_mem.sv
// Interval storage: one write port, one read port with registered data.
// Depends on sit_pkg.
module sit_mem #(
  parameter int ENTRIES = sit_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  sit_pkg::entry_t            wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output sit_pkg::entry_t            rd_data
);

  sit_pkg::entry_t mem [ENTRIES];
  sit_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sit_cmp.sv
// Shared compare unit: tests one stored entry against the item's key.
// Depends on sit_pkg.
module sit_cmp (
  input  sit_pkg::op_t     op,
  input  sit_pkg::time_t   key_start,
  input  sit_pkg::time_t   key_end,
  input  logic             clip,
  input  sit_pkg::entry_t  ent,
  output sit_pkg::cmp_res_t res
);

  always_comb begin
    res = '{hit: 1'b0, ent: ent};
    unique case (op)
      sit_pkg::OP_INSERT: begin
        // shift up every entry that starts later than the new one
        res.hit = ent.t_start > key_start;
      end
      sit_pkg::OP_REMOVE: begin
        res.hit = (ent.t_start == key_start) && (ent.t_end == key_end);
      end
      sit_pkg::OP_QUERY: begin
        res.hit = (ent.t_end > key_start) && (ent.t_start < key_end);
        if (clip) begin
          res.ent.t_start = (key_start > ent.t_start) ? key_start : ent.t_start;
          res.ent.t_end   = (key_end < ent.t_end) ? key_end : ent.t_end;
        end
      end
      sit_pkg::OP_READ_ALL: begin
        res.hit = 1'b1;
      end
      default: res.hit = 1'b0;
    endcase
  end

endmodule

FILE: rtl/sit_seq.sv
// Sequencer: walks the table one entry per cycle through the memory read
// port and the shared compare unit, unless stalled. Needs sit_pkg, sit_cmp.
module sit_seq #(
  parameter int ENTRIES = sit_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sit_pkg::op_t               in_op,
  input  sit_pkg::time_t             in_start,
  input  sit_pkg::time_t             in_end,
  input  logic                       in_clip,
  output logic                       res_valid,
  input  logic                       res_ready,
  output sit_pkg::result_t           res,
  output logic                       wr_en,
  output logic [$clog2(ENTRIES)-1:0] wr_addr,
  output sit_pkg::entry_t            wr_data,
  output logic                       rd_en,
  output logic [$clog2(ENTRIES)-1:0] rd_addr,
  input  sit_pkg::entry_t            rd_data
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int NRW  = sit_pkg::NRES_W;

  sit_pkg::state_t  state_r, state_nxt;
  sit_pkg::op_t     op_r, op_nxt;
  sit_pkg::time_t   key_start_r, key_start_nxt;
  sit_pkg::time_t   key_end_r, key_end_nxt;
  logic             clip_r, clip_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic [CNTW-1:0]  left_r, left_nxt;
  logic [IDXW-1:0]  iss_addr_r, iss_addr_nxt;
  logic             dv_r, dv_nxt;
  logic [IDXW-1:0]  d_addr_r, d_addr_nxt;
  logic             found_r, found_nxt;
  logic             pend_v_r, pend_v_nxt;
  sit_pkg::entry_t  pend_r, pend_nxt;
  sit_pkg::status_t pend_status_r, pend_status_nxt;
  logic [NRW-1:0]   nmatch_r, nmatch_nxt;

  sit_pkg::cmp_res_t cmp;
  logic              listing;
  logic              full;
  logic              scan_done;
  logic              emit_mid;
  logic              stall;
  logic              cap_hit;
  logic [CNTW-1:0]   cnt_m1;

  sit_cmp u_cmp (
    .op        (op_r),
    .key_start (key_start_r),
    .key_end   (key_end_r),
    .clip      (clip_r),
    .ent       (rd_data),
    .res       (cmp)
  );

  assign listing   = (op_r == sit_pkg::OP_QUERY) || (op_r == sit_pkg::OP_READ_ALL);
  assign full      = (count_r == CNTW'(ENTRIES));
  assign scan_done = (left_r == '0) && !dv_r;
  assign emit_mid  = (state_r == sit_pkg::S_SCAN) && listing && dv_r && cmp.hit && pend_v_r;
  assign stall     = emit_mid && !res_ready;
  assign cap_hit   = listing && dv_r && cmp.hit &&
                     (nmatch_r == NRW'(sit_pkg::MAX_RESULTS - 1));
  assign cnt_m1    = count_r - CNTW'(1);

  assign in_ready  = (state_r == sit_pkg::S_IDLE);
  assign res_valid = emit_mid || (state_r == sit_pkg::S_FINISH);
  assign res       = '{ent: pend_r, status: pend_status_r,
                       last: (state_r == sit_pkg::S_FINISH)};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sit_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == sit_pkg::OP_INSERT && full) begin
            state_nxt = sit_pkg::S_FINISH;
          end else begin
            state_nxt = sit_pkg::S_SCAN;
          end
        end
      end
      sit_pkg::S_SCAN: begin
        if (!stall) begin
          if (dv_r && op_r == sit_pkg::OP_INSERT && !cmp.hit) begin
            state_nxt = sit_pkg::S_FINISH;
          end else if (cap_hit || scan_done) begin
            state_nxt = sit_pkg::S_FINISH;
          end
        end
      end
      sit_pkg::S_FINISH: begin
        if (res_ready) begin
          state_nxt = sit_pkg::S_IDLE;
        end
      end
      default: state_nxt = sit_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt          = op_r;
    key_start_nxt   = key_start_r;
    key_end_nxt     = key_end_r;
    clip_nxt        = clip_r;
    count_nxt       = count_r;
    left_nxt        = left_r;
    iss_addr_nxt    = iss_addr_r;
    dv_nxt          = dv_r;
    d_addr_nxt      = d_addr_r;
    found_nxt       = found_r;
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    nmatch_nxt      = nmatch_r;
    wr_en           = 1'b0;
    wr_addr         = d_addr_r;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = iss_addr_r;

    if (state_r == sit_pkg::S_IDLE && in_valid) begin
      op_nxt          = in_op;
      key_start_nxt   = in_start;
      key_end_nxt     = in_end;
      clip_nxt        = in_clip;
      left_nxt        = count_r;
      // insert walks downward from the top entry, all others upward
      iss_addr_nxt    = (in_op == sit_pkg::OP_INSERT) ? cnt_m1[IDXW-1:0] : '0;
      dv_nxt          = 1'b0;
      found_nxt       = 1'b0;
      pend_v_nxt      = 1'b0;
      nmatch_nxt      = '0;
      pend_nxt        = '0;
      pend_status_nxt = (in_op == sit_pkg::OP_INSERT && full) ?
                        sit_pkg::STAT_FULL : sit_pkg::STAT_OK;
    end else if (state_r == sit_pkg::S_SCAN && !stall) begin
      if (left_r != '0) begin
        rd_en        = 1'b1;
        iss_addr_nxt = (op_r == sit_pkg::OP_INSERT) ? iss_addr_r - IDXW'(1)
                                                     : iss_addr_r + IDXW'(1);
        left_nxt     = left_r - CNTW'(1);
        dv_nxt       = 1'b1;
        d_addr_nxt   = iss_addr_r;
      end else begin
        dv_nxt = 1'b0;
      end

      if (dv_r) begin
        unique case (op_r)
          sit_pkg::OP_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = d_addr_r + IDXW'(1);
            if (!cmp.hit) begin
              wr_data   = '{t_start: key_start_r, t_end: key_end_r};
              count_nxt = count_r + CNTW'(1);
            end
          end
          sit_pkg::OP_REMOVE: begin
            if (found_r) begin
              // close the gap: move this entry down one place
              wr_en   = 1'b1;
              wr_addr = d_addr_r - IDXW'(1);
            end else if (cmp.hit) begin
              found_nxt = 1'b1;
            end
          end
          sit_pkg::OP_QUERY, sit_pkg::OP_READ_ALL: begin
            if (cmp.hit) begin
              pend_nxt   = cmp.ent;
              pend_v_nxt = 1'b1;
              nmatch_nxt = nmatch_r + NRW'(1);
            end
          end
          default: ;
        endcase
      end

      if (scan_done) begin
        case (op_r)
          sit_pkg::OP_INSERT: begin
            // every stored entry starts later: new entry goes first
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '{t_start: key_start_r, t_end: key_end_r};
            count_nxt = count_r + CNTW'(1);
          end
          sit_pkg::OP_REMOVE: begin
            if (found_r) begin
              count_nxt = cnt_m1;
            end else begin
              pend_status_nxt = sit_pkg::STAT_NOT_FOUND;
            end
          end
          default: begin
            if (!pend_v_r) begin
              pend_status_nxt = sit_pkg::STAT_NONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sit_pkg::S_IDLE;
      count_r  <= '0;
      dv_r     <= 1'b0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
      left_r   <= '0;
      nmatch_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      dv_r     <= dv_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      left_r   <= left_nxt;
      nmatch_r <= nmatch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    key_start_r   <= key_start_nxt;
    key_end_r     <= key_end_nxt;
    clip_r        <= clip_nxt;
    iss_addr_r    <= iss_addr_nxt;
    d_addr_r      <= d_addr_nxt;
    pend_r        <= pend_nxt;
    pend_status_r <= pend_status_nxt;
  end

endmodule

FILE: rtl/sorted_interval_table_top.sv
// Top level of the sorted interval table: stream ports, sequencer, storage
// and output register. Depends on sit_pkg, sit_mem and sit_seq.
//
// Keeps up to ENTRIES time intervals sorted by start time and serves one
// operation per input item: insert (after all entries with a start not
// later, so equal starts keep arrival order; status full when no room),
// remove (first entry with matching start and end, else status not found),
// overlap query (entries with end after the window start and start before
// the window end, in table order, optionally clipped to the window) and
// read-all. Insert and remove give one status item; query and read-all give
// one item per listed entry, at most 16, the final one marked by tlast, or
// a single status item "none" when nothing is listed. Status items carry
// zero start and end. The sequencer visits the stored entries one per cycle
// through the single memory read port and the shared compare unit, unless
// a stalled consumer holds it. An item passes through its acceptance, one
// read per stored entry, the registered read data, the close of the scan
// and a final state that gives the last result. An insert stops as soon as
// it finds its slot; an insert into a full table goes straight to the final
// state. The input is not ready while an item is being worked on. Results
// pass through a one-item output register, so a waiting result does not
// block the next input item; a stalled consumer pauses the scan in place.
module sorted_interval_table_top #(
  parameter int ENTRIES = sit_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] start_time, [63:32] end_time, [64] clip_to_window, rest zero
  input  logic [sit_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] out_start, [63:32] out_end
  output logic [sit_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam int IDXW = $clog2(ENTRIES);

  logic             wr_en;
  logic [IDXW-1:0]  wr_addr;
  sit_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [IDXW-1:0]  rd_addr;
  sit_pkg::entry_t  rd_data;

  logic             res_valid;
  logic             res_ready;
  sit_pkg::result_t res;

  logic             out_valid_r;
  sit_pkg::result_t out_res_r;

  sit_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sit_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (sit_pkg::op_t'(in_tuser)),
    .in_start  (in_tdata[31:0]),
    .in_end    (in_tdata[63:32]),
    .in_clip   (in_tdata[64]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Output register: take a new item whenever the held one is gone or leaving.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.ent.t_end, out_res_r.ent.t_start};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

FILE: tb/sv/sorted_interval_table_top_test.sv
// Self-checking testbench for sorted_interval_table_top: directed table, then random traffic.
// Uses the types and constants of sit_pkg; needs only the RTL under rtl/.
module sorted_interval_table_top_test;
  import sit_pkg::*;

  localparam int TBL_DEPTH    = ENTRIES_DEF;
  localparam int RAND_ITEMS   = 380;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_ROWS     = 20;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [31:0] start_time, [63:32] end_time, [64] clip_to_window, rest zero
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // [1:0] op
  logic [1:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [31:0] out_start, [63:32] out_end
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [1:0] status
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  sorted_interval_table_top #(.ENTRIES(TBL_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the interval table, kept sorted by start.
  time_t   tbl_start [TBL_DEPTH];
  time_t   tbl_end   [TBL_DEPTH];
  int      tbl_count = 0;

  result_t step_results [$];   // results of the item just accepted
  result_t expected_q   [$];   // results still owed by the block
  int      err_count    = 0;
  int      burst_left   = 0;
  bit      hold_off_req = 1'b0;

  typedef struct {
    op_t     op;
    time_t   t0;
    time_t   t1;
    bit      clip;
    int      rep;
    bit      typed;     // 1: single status item given by st
    status_t st;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(8_000_000);
    $display("sorted_interval_table_top_test: done, errors");
    $finish;
  end

  function automatic result_t mk_result(time_t s, time_t e, status_t st, logic lst);
    result_t r;
    r.ent.t_start = s;
    r.ent.t_end   = e;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  // Apply one item to the shadow table and collect the results it causes.
  function automatic void table_step(op_t op, time_t s, time_t e, bit clip);
    int    pos;
    int    i;
    int    n;
    bit    found;
    time_t rs;
    time_t re;
    step_results.delete();
    case (op)
      OP_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          step_results.push_back(mk_result('0, '0, STAT_FULL, 1'b1));
        end else begin
          // Place after every entry whose start is not later: ties keep order.
          pos = 0;
          while (pos < tbl_count && tbl_start[pos] <= s) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_end[i]   = tbl_end[i-1];
          end
          tbl_start[pos] = s;
          tbl_end[pos]   = e;
          tbl_count++;
          step_results.push_back(mk_result('0, '0, STAT_OK, 1'b1));
        end
      end
      OP_REMOVE: begin
        found = 1'b0;
        i = 0;
        while (!found && i < tbl_count) begin
          if (tbl_start[i] == s && tbl_end[i] == e) begin
            for (pos = i; pos + 1 < tbl_count; pos++) begin
              tbl_start[pos] = tbl_start[pos+1];
              tbl_end[pos]   = tbl_end[pos+1];
            end
            tbl_count--;
            found = 1'b1;
          end
          i++;
        end
        step_results.push_back(mk_result('0, '0, found ? STAT_OK : STAT_NOT_FOUND, 1'b1));
      end
      default: begin
        n = 0;
        for (i = 0; i < tbl_count && n < MAX_RESULTS; i++) begin
          rs = tbl_start[i];
          re = tbl_end[i];
          // Read-all lists everything; a query keeps strict overlaps only.
          if (op == OP_READ_ALL || (re > s && rs < e)) begin
            if (op == OP_QUERY && clip) begin
              if (s > rs) rs = s;
              if (e < re) re = e;
            end
            step_results.push_back(mk_result(rs, re, STAT_OK, 1'b0));
            n++;
          end
        end
        if (n == 0) step_results.push_back(mk_result('0, '0, STAT_NONE, 1'b1));
        else step_results[n-1].last = 1'b1;
      end
    endcase
  endfunction

  // Offer one item; open a new burst after a random gap when the old one runs out.
  task automatic send_item(op_t op, time_t t0, time_t t1, bit clip);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, clip, t1, t0};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic time_t rand_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Receiver: stretches of always-ready, coin-flip and sparse ready, plus
  // a long hold-off on request so the block backs up into its input.
  initial begin
    int rx_mode;
    int stretch_left;
    rx_mode = 0;
    stretch_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 60);
        end
        stretch_left--;
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
      err_count++;
    end
  endfunction

  // Compare every accepted result against the oldest outstanding one.
  always @(posedge clk) begin : result_mon
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got start %0h end %0h status %0d",
                 $time, out_tdata[31:0], out_tdata[63:32], out_tuser);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("start",  want.ent.t_start, out_tdata[31:0]);
        check_field("end",    want.ent.t_end,   out_tdata[63:32]);
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("last",   32'(want.last),   32'(out_tlast));
      end
    end
  end

  initial begin
    int    r;
    int    k;
    int    pick;
    bit    fill;
    op_t   op;
    time_t t0;
    time_t t1;

    dir_tab = '{
      '{OP_READ_ALL, 32'd0,         32'd0,         1'b0, 1,  1'b1, STAT_NONE},
      '{OP_QUERY,    32'd0,         32'hFFFF_FFFF, 1'b1, 1,  1'b1, STAT_NONE},
      '{OP_REMOVE,   32'hFFFF_FFFF, 32'd0,         1'b0, 1,  1'b1, STAT_NOT_FOUND},
      '{OP_INSERT,   32'd0,         32'd0,         1'b1, 1,  1'b1, STAT_OK},
      '{OP_INSERT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1,  1'b1, STAT_OK},
      '{OP_INSERT,   32'd100,       32'd300,       1'b0, 1,  1'b1, STAT_OK},
      '{OP_INSERT,   32'd100,       32'd200,       1'b0, 1,  1'b1, STAT_OK},
      '{OP_INSERT,   32'd50,        32'hFFFF_FFFF, 1'b0, 1,  1'b1, STAT_OK},
      '{OP_READ_ALL, 32'd0,         32'd0,         1'b1, 1,  1'b0, STAT_OK},
      '{OP_QUERY,    32'd150,       32'd250,       1'b1, 1,  1'b0, STAT_OK},
      '{OP_QUERY,    32'd150,       32'd250,       1'b0, 1,  1'b0, STAT_OK},
      '{OP_QUERY,    32'd250,       32'd150,       1'b1, 1,  1'b0, STAT_OK},
      '{OP_QUERY,    32'd0,         32'hFFFF_FFFF, 1'b1, 1,  1'b0, STAT_OK},
      '{OP_REMOVE,   32'd100,       32'd300,       1'b0, 1,  1'b1, STAT_OK},
      '{OP_REMOVE,   32'd100,       32'd301,       1'b1, 1,  1'b1, STAT_NOT_FOUND},
      '{OP_INSERT,   32'd7,         32'd9,         1'b0, 12, 1'b1, STAT_OK},
      '{OP_INSERT,   32'd1,         32'd2,         1'b0, 1,  1'b1, STAT_FULL},
      '{OP_READ_ALL, 32'd0,         32'd0,         1'b0, 1,  1'b0, STAT_OK},
      '{OP_QUERY,    32'd8,         32'd8,         1'b0, 1,  1'b0, STAT_OK},
      '{OP_REMOVE,   32'd7,         32'd9,         1'b0, 1,  1'b1, STAT_OK}
    };

    // Hold reset, then release it on a clock edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: typed status where it is obvious, shadow table elsewhere.
    for (r = 0; r < DIR_ROWS; r++) begin
      for (k = 0; k < dir_tab[r].rep; k++) begin
        send_item(dir_tab[r].op, dir_tab[r].t0, dir_tab[r].t1, dir_tab[r].clip);
        table_step(dir_tab[r].op, dir_tab[r].t0, dir_tab[r].t1, dir_tab[r].clip);
        if (dir_tab[r].typed)
          expected_q.push_back(mk_result('0, '0, dir_tab[r].st, 1'b1));
        else
          foreach (step_results[i]) expected_q.push_back(step_results[i]);
      end
    end

    // Random traffic: alternate fill-heavy and drain-heavy phases so the table
    // swings between full and empty; removes mostly target stored entries.
    hold_off_req = 1'b1;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) hold_off_req = 1'b1;
      fill = ((k / 50) % 2 == 0);
      pick = $urandom_range(0, 99);
      if (pick < (fill ? 55 : 15))  op = OP_INSERT;
      else if (pick < 70)           op = OP_REMOVE;
      else if (pick < 90)           op = OP_QUERY;
      else                          op = OP_READ_ALL;
      t0 = rand_time();
      t1 = rand_time();
      if (op == OP_INSERT && $urandom_range(0, 1) == 1) t1 = t0 + $urandom_range(0, 300);
      if (op == OP_REMOVE && tbl_count > 0 && $urandom_range(0, 3) != 0) begin
        r  = $urandom_range(0, tbl_count - 1);
        t0 = tbl_start[r];
        t1 = tbl_end[r];
      end
      send_item(op, t0, t1, $urandom_range(0, 1));
      table_step(op, t0, t1, in_tdata[64]);
      foreach (step_results[i]) expected_q.push_back(step_results[i]);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every owed result, then give stray results time to show.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sorted_interval_table_top_test: done, clean");
    end else begin
      $display("sorted_interval_table_top_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sit_pkg.sv
rtl/sit_mem.sv
rtl/sit_cmp.sv
rtl/sit_seq.sv
rtl/sorted_interval_table_top.sv
tb/sv/sorted_interval_table_top_test.sv
